// ----- rtl/core/bounded_max_xor_trie_macros.svh -----
// assertion macros for the bounded max xor trie block
`ifndef BOUNDED_MAX_XOR_TRIE_MACROS_SVH
`define BOUNDED_MAX_XOR_TRIE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMXT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BMXT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bmxt_pkg.sv -----
// shared types and constants of the bounded max xor trie block
`default_nettype none

package bmxt_pkg;

    // default sizes of the node store and the key
    localparam int DEF_NODE_CAPACITY = 32768;
    localparam int DEF_KEY_BITS      = 32;

    // fixed payload widths
    localparam int KEY_W    = 32;
    localparam int LIMIT_W  = 32;
    localparam int XOR_W    = 32;
    localparam int STATUS_W = 2;

    // transaction kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_FOUND    = 2'd1,
        STATUS_NONE     = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    // control states of the walk sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/bmxt_if.sv -----
// request and response channel interfaces of the bounded max xor trie block
`default_nettype none

interface bmxt_req_if;
    import bmxt_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [LIMIT_W-1:0] limit;

    modport source (output valid, kind, key, limit, input ready);
    modport sink   (input valid, kind, key, limit, output ready);
endinterface

interface bmxt_rsp_if;
    import bmxt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [XOR_W-1:0]    max_xor;

    modport source (output valid, status, max_xor, input ready);
    modport sink   (input valid, status, max_xor, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bmxt_node_ram.sv -----
// single-port-write, single-port-read node store with registered read data
`default_nettype none

module bmxt_node_ram #(
    parameter int DEPTH  = bmxt_pkg::DEF_NODE_CAPACITY,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bounded_max_xor_trie.sv -----
// a walking transaction passes the walk state, then the done state registers its result;
// a full, empty or over-limit transaction goes straight to the done state, which waits
// while a held response is not taken. The walk visits one trie level per cycle through the
// single read port of the node store, and a new transaction is accepted only when idle
// reset: the root is emptied and the node count set to one; no clearing pass, node
// entries are written whole when first visited after allocation; bottom-level ones never are
`default_nettype none

module bounded_max_xor_trie #(
    parameter int NODE_CAPACITY = bmxt_pkg::DEF_NODE_CAPACITY,
    parameter int KEY_BITS      = bmxt_pkg::DEF_KEY_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    bmxt_req_if.sink    req,
    bmxt_rsp_if.source  rsp
);
    import bmxt_pkg::*;

    localparam int AW      = $clog2(NODE_CAPACITY);
    localparam int KB      = KEY_BITS;
    localparam int ENTRY_W = 2 * AW + 2 * KB;
    localparam int LVL_W   = (KB > 1) ? $clog2(KB) : 1;
    localparam logic [AW:0] FULL_MARK = (AW + 1)'(NODE_CAPACITY - KEY_BITS);
    localparam logic [AW:0] CAP_COUNT = (AW + 1)'(NODE_CAPACITY);

    // sequencer state
    state_t state_reg, state_next;

    // transaction registers
    logic               kind_reg, kind_next;
    logic [KB-1:0]      key_reg, key_next;
    logic [KB-1:0]      key_sh_reg, key_sh_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [KB-1:0]      acc_reg, acc_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic               fresh_reg, fresh_next;
    logic               stop_reg, stop_next;
    status_t            res_reg, res_next;

    // trie bookkeeping, root kept in flops
    logic [AW:0]        nodes_used_reg, nodes_used_next;
    logic [ENTRY_W-1:0] root_entry_reg, root_entry_next;
    logic [KB-1:0]      root_min_reg, root_min_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [XOR_W-1:0]   out_xor_reg, out_xor_next;

    // node store port
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // walk datapath
    logic [ENTRY_W-1:0] cur_entry;
    logic [AW-1:0]      cur_zl, cur_ol;
    logic [KB-1:0]      cur_zm, cur_om;
    logic               cur_bit;
    logic [AW-1:0]      link_same, link_opp;
    logic [KB-1:0]      min_same, min_opp;
    logic               opp_ok;
    logic [AW-1:0]      alloc_idx;
    logic [AW-1:0]      ins_link;
    logic [KB-1:0]      ins_min;
    logic [ENTRY_W-1:0] new_entry;

    // acceptance checks
    logic               in_full, in_none, go_walk, out_free;

    bmxt_node_ram #(
        .DEPTH  (NODE_CAPACITY),
        .ADDR_W (AW),
        .DATA_W (ENTRY_W)
    ) u_node_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // current node entry: root flops, a just-allocated empty node, or the store
    always_comb
    begin
        if (cur_reg == '0)
        begin
            cur_entry = root_entry_reg;
        end
        else if (fresh_reg)
        begin
            cur_entry = '0;
        end
        else
        begin
            cur_entry = rd_data;
        end
    end

    assign cur_zl = cur_entry[ENTRY_W-1 -: AW];
    assign cur_ol = cur_entry[2*KB+AW-1 -: AW];
    assign cur_zm = cur_entry[2*KB-1 -: KB];
    assign cur_om = cur_entry[KB-1:0];

    // one key bit per level, most significant first
    assign cur_bit   = key_sh_reg[KB-1];
    assign link_same = cur_bit ? cur_ol : cur_zl;
    assign min_same  = cur_bit ? cur_om : cur_zm;
    assign link_opp  = cur_bit ? cur_zl : cur_ol;
    assign min_opp   = cur_bit ? cur_zm : cur_om;
    assign opp_ok    = (link_opp != '0) && (LIMIT_W'(min_opp) <= limit_reg);

    // insert update of the current node
    assign alloc_idx = nodes_used_reg[AW-1:0];
    assign ins_link  = (link_same == '0) ? alloc_idx : link_same;
    assign ins_min   = ((link_same == '0) || (key_reg < min_same)) ? key_reg : min_same;
    assign new_entry = cur_bit ? {cur_zl, ins_link, cur_zm, ins_min}
                               : {ins_link, cur_ol, ins_min, cur_om};

    // checks on an incoming transaction
    assign in_full  = (nodes_used_reg > FULL_MARK);
    assign in_none  = ((root_entry_reg[ENTRY_W-1 -: AW] == '0) &&
                       (root_entry_reg[2*KB+AW-1 -: AW] == '0)) ||
                      (LIMIT_W'(root_min_reg) > req.limit);
    assign go_walk  = (req.kind == KIND_QUERY) ? !in_none : !in_full;
    assign out_free = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = go_walk ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        kind_next       = kind_reg;
        key_next        = key_reg;
        key_sh_next     = key_sh_reg;
        limit_next      = limit_reg;
        acc_next        = acc_reg;
        lvl_next        = lvl_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        stop_next       = stop_reg;
        res_next        = res_reg;
        nodes_used_next = nodes_used_reg;
        root_entry_next = root_entry_reg;
        root_min_next   = root_min_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_xor_next    = out_xor_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = new_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next   = req.kind;
                    key_next    = req.key[KB-1:0];
                    key_sh_next = req.key[KB-1:0];
                    limit_next  = req.limit;
                    acc_next    = '0;
                    lvl_next    = LVL_W'(KB - 1);
                    cur_next    = '0;
                    fresh_next  = 1'b0;
                    stop_next   = 1'b0;
                    if (req.kind == KIND_INSERT)
                    begin
                        if (in_full)
                        begin
                            res_next = STATUS_FULL;
                        end
                        else
                        begin
                            res_next = STATUS_INSERTED;
                            if (req.key[KB-1:0] < root_min_reg)
                            begin
                                root_min_next = req.key[KB-1:0];
                            end
                        end
                    end
                    else
                    begin
                        res_next = in_none ? STATUS_NONE : STATUS_FOUND;
                    end
                end
            end
            ST_WALK:
            begin
                key_sh_next = key_sh_reg << 1;
                lvl_next    = LVL_W'(lvl_reg - 1'b1);
                acc_next    = acc_reg << 1;
                fresh_next  = 1'b0;
                if (kind_reg == KIND_INSERT)
                begin
                    // update the node, allocate a child where the branch is missing
                    if (cur_reg == '0)
                    begin
                        root_entry_next = new_entry;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                    if (link_same == '0)
                    begin
                        nodes_used_next = (AW + 1)'(nodes_used_reg + 1'b1);
                        fresh_next      = 1'b1;
                    end
                    cur_next = ins_link;
                    rd_en    = (lvl_reg != '0) && (link_same != '0);
                    rd_addr  = ins_link;
                end
                else if (!stop_reg)
                begin
                    // prefer the opposite branch when it holds a key within limit
                    if (opp_ok)
                    begin
                        acc_next = (acc_reg << 1) | KB'(1);
                        cur_next = link_opp;
                        rd_en    = (lvl_reg != '0);
                        rd_addr  = link_opp;
                    end
                    else if (link_same != '0)
                    begin
                        cur_next = link_same;
                        rd_en    = (lvl_reg != '0);
                        rd_addr  = link_same;
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_xor_next    = (res_reg == STATUS_FOUND) ? XOR_W'(acc_reg) : '0;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            nodes_used_reg <= (AW + 1)'(1);
            root_entry_reg <= '0;
            root_min_reg   <= '1;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            nodes_used_reg <= nodes_used_next;
            root_entry_reg <= root_entry_next;
            root_min_reg   <= root_min_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        key_sh_reg     <= key_sh_next;
        limit_reg      <= limit_next;
        acc_reg        <= acc_next;
        lvl_reg        <= lvl_next;
        cur_reg        <= cur_next;
        fresh_reg      <= fresh_next;
        stop_reg       <= stop_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_xor_reg    <= out_xor_next;
    end

    // channel outputs
    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.max_xor = out_xor_reg;

`include "bounded_max_xor_trie_macros.svh"

    // node count never passes the store size
    `BMXT_ASSERT_IMP(a_nodes_bound, 1'b1, nodes_used_reg <= CAP_COUNT, "node count overflow")
    // only a found query carries a nonzero xor
    `BMXT_ASSERT_IMP(a_xor_zero,
        rsp.valid && (rsp.status != STATUS_FOUND),
        rsp.max_xor == '0, "xor on non-found result")
    // a refused insert allocates nothing
    `BMXT_ASSERT_NXT(a_full_stable,
        req.valid && req.ready && (req.kind == KIND_INSERT) && in_full,
        $stable(nodes_used_reg), "refused insert changed node count")
    // the walk ends after the bottom level
    `BMXT_ASSERT_NXT(a_walk_end,
        (state_reg == ST_WALK) && (lvl_reg == '0),
        state_reg == ST_DONE, "walk did not end at bottom level")

endmodule

`default_nettype wire
